// ===== src/encoder_pid_speed_controller_assert.svh =====
// Assertion macros for the encoder PID speed controller.
// Expects signals clk and rst in the scope of use.
`ifndef ENCODER_PID_SPEED_CONTROLLER_ASSERT_SVH
`define ENCODER_PID_SPEED_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define ECPSC_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define ECPSC_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== src/ecpsc_pkg.sv =====
// Shared types and constants for the encoder PID speed controller.
// No dependencies.
`default_nettype none

package ecpsc_pkg;

  localparam int unsigned DUTY_MAX_DEF   = 4095;
  localparam int unsigned TALLY_BITS_DEF = 16;

  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_TO_RPM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT  = 3'd4;

  localparam logic [31:0] COUNT_TO_RPM_RST = 32'h0001_0000;
  localparam logic [14:0] SPEED_LIMIT_RST  = 15'h7FFF;

  localparam int unsigned SUM_W  = 40;
  localparam int unsigned ERR_W  = 33;
  localparam int unsigned DIFF_W = 34;
  localparam int unsigned ACC_W  = 76;
  localparam int unsigned DUTY_W = 16;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic [0:0] REQ_EDGE = 1'b0;
  localparam logic [0:0] REQ_TICK = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic              chan_b_level;
    logic signed [15:0] speed_target;
  } req_t;

  typedef struct packed {
    logic [11:0]        duty_level;
    logic               rotation_dir;
    logic signed [31:0] speed_seen;
  } rsp_t;

endpackage

`default_nettype wire

// ===== src/encoder_pid_speed_controller.sv =====
// Encoder-fed PID speed controller, top level.
// Depends on ecpsc_pkg and encoder_pid_speed_controller_assert.svh.
// An encoder edge word steps the tally when accepted; a tick word is accepted, then runs
// 11 sequencer steps, and its result word is valid after the last step.
// One edge per cycle while idle; no new word is taken until a tick's result word is issued.
// A single shared 33x21 multiplier makes two passes per 32x40 product, four products in all.
// Reset (rst, synchronous): registers take their defaults, tally and PID state clear.
`default_nettype none

module encoder_pid_speed_controller #(
  parameter int unsigned DUTY_MAX   = ecpsc_pkg::DUTY_MAX_DEF,
  parameter int unsigned TALLY_BITS = ecpsc_pkg::TALLY_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // request channel
  input  wire logic                           req_valid,
  output      logic                           req_stall,
  input  wire ecpsc_pkg::req_t                req,
  // result channel
  output      logic                           rsp_valid,
  input  wire logic                           rsp_stall,
  output      ecpsc_pkg::rsp_t                rsp,
  // configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [ecpsc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [ecpsc_pkg::CFG_W-1:0]     cfg_data
);
  import ecpsc_pkg::*;

  // sequencer codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SLO  = 4'd1;   // speed product, low chunk
  localparam logic [3:0] ST_SHI  = 4'd2;   // speed product, high chunk
  localparam logic [3:0] ST_SPD  = 4'd3;   // round, saturate, form error
  localparam logic [3:0] ST_ERR  = 4'd4;   // integral and difference update
  localparam logic [3:0] ST_PLO  = 4'd5;
  localparam logic [3:0] ST_PHI  = 4'd6;
  localparam logic [3:0] ST_ILO  = 4'd7;
  localparam logic [3:0] ST_IHI  = 4'd8;
  localparam logic [3:0] ST_DLO  = 4'd9;
  localparam logic [3:0] ST_DHI  = 4'd10;
  localparam logic [3:0] ST_OUT  = 4'd11;  // drive to duty and direction

  localparam int unsigned B_W     = SUM_W;   // multiplier B operand in word form
  localparam int unsigned CHUNK   = B_W / 2;
  localparam int unsigned PROD_W  = 33 + CHUNK + 1;

  // configuration registers
  logic signed [31:0] prop_gain, integ_gain, deriv_gain;
  logic        [31:0] count_to_rpm;
  logic        [14:0] speed_limit;

  // controller state
  logic [TALLY_BITS-1:0]    tally;
  logic signed [SUM_W-1:0]  error_sum;
  logic signed [ERR_W-1:0]  last_error;

  // per-tick working registers
  logic [3:0]               state;
  logic signed [15:0]       target_q;
  logic signed [ERR_W-1:0]  err_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [31:0]       speed_q;
  logic signed [ACC_W-1:0]  acc;

  logic req_take, rsp_take, is_tick;
  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_take  = rsp_valid && !rsp_stall;
  assign is_tick   = (req.req_type == REQ_TICK);

  // target clamp, done at accept
  logic signed [15:0] lim_pos, lim_neg, target_clamped;
  always_comb begin
    lim_pos = {1'b0, speed_limit};
    lim_neg = -lim_pos;
    if (req.speed_target > lim_pos) begin
      target_clamped = lim_pos;
    end else if (req.speed_target < lim_neg) begin
      target_clamped = lim_neg;
    end else begin
      target_clamped = req.speed_target;
    end
  end

  // tally magnitude; tally holds still until the error step
  logic                  tally_neg;
  logic [TALLY_BITS-1:0] tally_mag;
  assign tally_neg = tally[TALLY_BITS-1];
  assign tally_mag = tally_neg ? (~tally + 1'b1) : tally;

  // shared multiplier: 33-bit signed A times one 20-bit chunk of a 40-bit B
  logic signed [32:0]       a_op;
  logic signed [B_W-1:0]    b_op;
  logic                     hi_sel;
  logic signed [CHUNK:0]    chunk;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext, term;

  always_comb begin
    unique case (state)
      ST_SLO, ST_SHI: begin
        a_op = {1'b0, count_to_rpm};
        b_op = {{(B_W-TALLY_BITS){1'b0}}, tally_mag};
      end
      ST_PLO, ST_PHI: begin
        a_op = {prop_gain[31], prop_gain};
        b_op = {{(B_W-ERR_W){err_q[ERR_W-1]}}, err_q};
      end
      ST_ILO, ST_IHI: begin
        a_op = {integ_gain[31], integ_gain};
        b_op = error_sum;
      end
      default: begin
        a_op = {deriv_gain[31], deriv_gain};
        b_op = {{(B_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q};
      end
    endcase
    hi_sel = (state == ST_SHI) || (state == ST_PHI) || (state == ST_IHI) ||
             (state == ST_DHI);
    chunk    = hi_sel ? {b_op[B_W-1], b_op[B_W-1:CHUNK]} : {1'b0, b_op[CHUNK-1:0]};
    prod     = a_op * chunk;
    prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    term     = hi_sel ? (prod_ext <<< CHUNK) : prod_ext;
  end

  // speed: round to nearest, ties away from zero, saturate to 32 bits
  logic [64:0]            rnd;
  logic [48:0]            r_mag;
  logic signed [31:0]     speed_calc;
  logic signed [ERR_W-1:0] err_calc;
  always_comb begin
    rnd   = {1'b0, acc[63:0]} + 65'h8000;
    r_mag = rnd[64:16];
    if (tally_neg) begin
      speed_calc = (r_mag > 49'h0_8000_0000) ? 32'sh8000_0000 : -$signed(r_mag[31:0]);
    end else begin
      speed_calc = (r_mag > 49'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(r_mag[31:0]);
    end
    err_calc = {{(ERR_W-16){target_q[15]}}, target_q} -
               {{(ERR_W-32){speed_calc[31]}}, speed_calc};
  end

  // saturating integral
  logic signed [SUM_W:0]    sum_wide;
  logic signed [SUM_W-1:0]  sum_next;
  always_comb begin
    sum_wide = {error_sum[SUM_W-1], error_sum} + {{(SUM_W+1-ERR_W){err_q[ERR_W-1]}}, err_q};
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_next = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_next = sum_wide[SUM_W-1:0];
    end
  end

  // drive: integer part by truncation toward zero, then clamp
  logic                 drive_neg;
  logic [ACC_W-1:0]     drive_mag;
  logic [ACC_W-17:0]    q;
  logic [DUTY_W-1:0]    duty_sat;
  always_comb begin
    drive_neg = acc[ACC_W-1];
    drive_mag = drive_neg ? (~acc + 1'b1) : acc;
    q         = drive_mag[ACC_W-1:16];
    if (q > (ACC_W-16)'(DUTY_MAX)) begin
      duty_sat = DUTY_W'(DUTY_MAX);
    end else begin
      duty_sat = q[DUTY_W-1:0];
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= '0;
      integ_gain   <= '0;
      deriv_gain   <= '0;
      count_to_rpm <= COUNT_TO_RPM_RST;
      speed_limit  <= SPEED_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_PROP_GAIN:    prop_gain    <= cfg_data;
        CFG_INTEG_GAIN:   integ_gain   <= cfg_data;
        CFG_DERIV_GAIN:   deriv_gain   <= cfg_data;
        CFG_COUNT_TO_RPM: count_to_rpm <= cfg_data;
        CFG_SPEED_LIMIT:  speed_limit  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tally      <= '0;
      error_sum  <= '0;
      last_error <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      // in the last step a taken word is replaced by the new one below
      if (rsp_take && (state != ST_OUT)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_take) begin
            if (is_tick) begin
              state <= ST_SLO;
            end else if (req.chan_b_level) begin
              tally <= tally - 1'b1;
            end else begin
              tally <= tally + 1'b1;
            end
          end
        end
        ST_SLO: state <= ST_SHI;
        ST_SHI: state <= ST_SPD;
        ST_SPD: state <= ST_ERR;
        ST_ERR: begin
          error_sum  <= sum_next;
          last_error <= err_q;
          tally      <= '0;
          state      <= ST_PLO;
        end
        ST_PLO: state <= ST_PHI;
        ST_PHI: state <= ST_ILO;
        ST_ILO: state <= ST_IHI;
        ST_IHI: state <= ST_DLO;
        ST_DLO: state <= ST_DHI;
        ST_DHI: state <= ST_OUT;
        ST_OUT: begin
          // hold here while the previous result word is still waiting
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        target_q <= target_clamped;
        acc      <= '0;
      end
      ST_SPD: begin
        speed_q <= speed_calc;
        err_q   <= err_calc;
      end
      ST_ERR: begin
        diff_q <= {err_q[ERR_W-1], err_q} - {last_error[ERR_W-1], last_error};
        acc    <= '0;
      end
      ST_OUT: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp.duty_level   <= duty_sat[11:0];
          rsp.rotation_dir <= drive_neg && (q != '0);
          rsp.speed_seen   <= speed_q;
        end
      end
      default: acc <= acc + term;
    endcase
  end

  `include "encoder_pid_speed_controller_assert.svh"

  `ECPSC_ASSERT_NXT(a_edge_count, req_take && !is_tick, (state == ST_IDLE) && (tally == ($past(req.chan_b_level) ? $past(tally) - 1'b1 : $past(tally) + 1'b1)), "edge word did not step the tally")
  `ECPSC_ASSERT_NXT(a_tick_start, req_take && is_tick, state == ST_SLO, "tick word did not start the sequencer")
  `ECPSC_ASSERT_NXT(a_tally_clear, state == ST_ERR, tally == '0, "tally not cleared by tick")
  `ECPSC_ASSERT_NXT(a_result_out, (state == ST_OUT) && !(rsp_valid && rsp_stall), rsp_valid && (state == ST_IDLE), "result word not issued")

endmodule

`default_nettype wire

// ===== tb/sv/tb_encoder_pid_speed_controller.sv =====
// Self-checking testbench for encoder_pid_speed_controller.
// Needs ecpsc_pkg and the controller RTL; it tracks tally and PID state on its own
// and checks every result word against a predicted duty, direction and speed.
module tb_encoder_pid_speed_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import ecpsc_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 16;          // tick busy time plus margin
  localparam int unsigned TIMEOUT_NS   = 10_000_000;  // timeout for the whole run
  localparam longint      SPD_MAX      = 64'sd2147483647;
  localparam longint      SPD_MIN      = -64'sd2147483648;
  localparam logic [14:0] SPD_LIMIT_SHADOW_RST = SPEED_LIMIT_RST;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // idle chance per cycle, in percent
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned fault_cnt  = 0;
  int unsigned edge_cnt   = 0;
  int unsigned tick_cnt   = 0;
  int unsigned result_cnt = 0;
  int unsigned write_cnt  = 0;

  // shadow registers and controller state
  logic signed [31:0]         kp_q  = '0;
  logic signed [31:0]         ki_q  = '0;
  logic signed [31:0]         kd_q  = '0;
  logic [31:0]                c2r_q = COUNT_TO_RPM_RST;
  logic [14:0]                lim_q = SPD_LIMIT_SHADOW_RST;
  logic [TALLY_BITS_DEF-1:0]  tally_q    = '0;
  longint                     err_sum_q  = 0;
  longint                     prev_err_q = 0;

  // tick results still owed by the controller, oldest first
  rsp_t tick_results_q[$];

  encoder_pid_speed_controller DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One PID step on a tick, a tally move on an edge.
  task automatic pid_predict(input req_t w);
    longint              tgt, lim, cnt, spd, err, dif;
    longint unsigned     mag, rnd;
    logic signed [127:0] a, b, drive;
    logic [127:0]        drive_mag;
    logic [63:0]         whole;
    logic                neg;
    rsp_t                r;
    if (w.req_type == REQ_EDGE) begin
      // channel B low counts up, high counts down; wraps at the tally width
      if (w.chan_b_level) tally_q = tally_q - 1'b1;
      else tally_q = tally_q + 1'b1;
    end else begin
      tgt = longint'($signed(w.speed_target));
      lim = longint'(lim_q);
      if (tgt > lim) tgt = lim;
      if (tgt < -lim) tgt = -lim;

      // measured rpm: |count| * scale, rounded half away from zero, saturated
      cnt = longint'($signed(tally_q));
      mag = (cnt < 0) ? -cnt : cnt;
      rnd = (mag * c2r_q + 64'h8000) >> 16;
      if (cnt < 0) spd = (rnd > 64'd2147483648) ? SPD_MIN : -longint'(rnd);
      else spd = (rnd > 64'd2147483647) ? SPD_MAX : longint'(rnd);

      err = tgt - spd;
      err_sum_q = err_sum_q + err;
      if (err_sum_q > longint'(SUM_MAX)) err_sum_q = longint'(SUM_MAX);
      if (err_sum_q < longint'(SUM_MIN)) err_sum_q = longint'(SUM_MIN);
      dif = err - prev_err_q;

      // exact sum, with 16 fraction bits, of the three products of Q16.16 gains
      a = kp_q; b = err;       drive = a * b;
      a = ki_q; b = err_sum_q; drive = drive + a * b;
      a = kd_q; b = dif;       drive = drive + a * b;

      // integer part by truncation toward zero, then clamp
      neg = drive[127];
      drive_mag = neg ? -drive : drive;
      if (drive_mag[127:80] != '0) whole = 64'(DUTY_MAX_DEF) + 1;
      else whole = drive_mag[79:16];
      r.duty_level   = (whole > DUTY_MAX_DEF) ? 12'(DUTY_MAX_DEF) : whole[11:0];
      r.rotation_dir = neg && (whole != '0);
      r.speed_seen   = spd[31:0];
      tick_results_q.push_back(r);

      prev_err_q = err;
      tally_q = '0;
    end
  endtask

  // Present one word, hold it until accepted, then account for it.
  task automatic send_word(input req_t w);
    while ($urandom_range(99) < send_gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (w.req_type == REQ_EDGE) edge_cnt++;
    else tick_cnt++;
    pid_predict(w);
  endtask

  // Stop sending, let the owed results come out, then let the pipe go quiet.
  task automatic settle();
    req_valid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    write_cnt++;
    case (idx)
      CFG_PROP_GAIN:    kp_q  = data;
      CFG_INTEG_GAIN:   ki_q  = data;
      CFG_DERIV_GAIN:   kd_q  = data;
      CFG_COUNT_TO_RPM: c2r_q = data;
      CFG_SPEED_LIMIT:  lim_q = data[14:0];
      default: ;  // unused index, controller ignores it
    endcase
  endtask

  function automatic req_t edge_word(input logic down);
    req_t w;
    w.req_type     = REQ_EDGE;
    w.chan_b_level = down;
    w.speed_target = 16'($urandom());  // don't care on edges
    return w;
  endfunction

  function automatic req_t tick_word(input logic [15:0] target);
    req_t w;
    w.req_type     = REQ_TICK;
    w.chan_b_level = 1'($urandom());   // don't care on ticks
    w.speed_target = target;
    return w;
  endfunction

  // Mostly small targets, some at and past the limit, some anywhere.
  function automatic logic [15:0] pick_target();
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = int'($urandom_range(4000)) - 2000;
      5, 6:          v = int'($urandom());
      7:             v = int'(lim_q);
      8:             v = -int'(lim_q);
      default:       v = ($urandom_range(1) ? 1 : -1) * (int'(lim_q) + 1);
    endcase
    return v[15:0];
  endfunction

  function automatic logic [31:0] pick_gain();
    int v;
    case ($urandom_range(5))
      0: return '0;
      1: begin
        v = int'($urandom_range(32'h8000));
        return $urandom_range(1) ? -v : v;
      end
      2: begin
        v = int'($urandom_range(32'h8_0000));
        return $urandom_range(1) ? -v : v;
      end
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(4))
      0: return 32'h0001_0000;
      1: return $urandom_range(32'h4_0000);
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    logic [31:0] d;
    d = $urandom();  // upper bits are junk the controller must drop
    case ($urandom_range(3))
      0: d[14:0] = '0;
      1: d[14:0] = '1;
      2: d[14:0] = 15'($urandom_range(3000));
      default: ;
    endcase
    return d;
  endfunction

  task automatic random_config();
    settle();
    write_reg(CFG_PROP_GAIN,    pick_gain());
    write_reg(CFG_INTEG_GAIN,   pick_gain());
    write_reg(CFG_DERIV_GAIN,   pick_gain());
    write_reg(CFG_COUNT_TO_RPM, pick_scale());
    write_reg(CFG_SPEED_LIMIT,  pick_limit());
  endtask

  // Reset values: all gains zero, so duty stays 0 and only speed moves.
  task automatic test_default_registers();
    send_word(edge_word(1'b0));
    send_word(edge_word(1'b0));
    send_word(edge_word(1'b1));
    send_word(tick_word(16'h8000));  // most negative target, clamped to -limit
    send_word(edge_word(1'b1));
    send_word(tick_word(16'h7FFF));
  endtask

  // Drive just below zero must give duty 0 and clockwise.
  task automatic test_small_negative_drive();
    settle();
    write_reg(CFG_PROP_GAIN, 32'hFFFF_FFFF);  // -1/65536
    write_reg(CFG_INTEG_GAIN, '0);
    write_reg(CFG_DERIV_GAIN, '0);
    send_word(tick_word(16'd1));             // drive -1 lsb
    send_word(edge_word(1'b0));
    send_word(tick_word(16'd0));             // err -1: drive +1 lsb
    settle();
    write_reg(CFG_PROP_GAIN, 32'hFFFF_0000);  // -1.0: one full count, ccw
    send_word(tick_word(16'd1));
  endtask

  // Gains, scale and limit at their ends.
  task automatic test_register_extremes();
    settle();
    write_reg(CFG_PROP_GAIN,    32'h7FFF_FFFF);
    write_reg(CFG_INTEG_GAIN,   32'h8000_0000);
    write_reg(CFG_DERIV_GAIN,   32'h8000_0000);
    write_reg(CFG_COUNT_TO_RPM, '1);
    write_reg(CFG_SPEED_LIMIT,  {17'($urandom()), 15'h0000});
    send_word(edge_word(1'b1));
    send_word(edge_word(1'b1));
    send_word(tick_word(16'h7FFF));          // limit 0 forces target 0
    send_word(tick_word(16'h8000));
    send_word(edge_word(1'b0));
    send_word(tick_word(16'($urandom())));
    settle();
    write_reg(CFG_SPEED_LIMIT,  {17'($urandom()), 15'h7FFF});
    write_reg(CFG_COUNT_TO_RPM, '0);
    send_word(edge_word(1'b0));
    send_word(tick_word(16'h8000));
    send_word(tick_word(16'h7FFF));
  endtask

  // Writes to indexes past the register list must change nothing.
  task automatic test_unused_indexes();
    settle();
    for (int i = int'(CFG_SPEED_LIMIT) + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), $urandom());
    send_word(edge_word(1'b0));
    send_word(tick_word(pick_target()));
  endtask

  // Long one-way edge runs at full scale give large speeds of both signs.
  task automatic test_long_runs();
    int unsigned run;
    run = 40;
    settle();
    write_reg(CFG_COUNT_TO_RPM, '1);
    write_reg(CFG_PROP_GAIN,  32'h0000_0100);
    write_reg(CFG_INTEG_GAIN, '0);
    write_reg(CFG_DERIV_GAIN, 32'hFFFF_FF00);
    repeat (run) send_word(edge_word(1'b0));
    send_word(tick_word(16'h7FFF));
    repeat (run + 1) send_word(edge_word(1'b1));
    send_word(tick_word(16'h8000));
  endtask

  // Realistic traffic: edge bursts closed by a tick, with some stray edges.
  task automatic test_random_traffic(input int unsigned goal_items,
                                     input int unsigned goal_ticks);
    int unsigned n_items, n_ticks, burst;
    logic        dir;
    n_items = 0;
    n_ticks = 0;
    while (n_items < goal_items || n_ticks < goal_ticks) begin
      if ($urandom_range(9) == 0) begin
        burst = $urandom_range(3);
        repeat (burst) send_word(edge_word(1'($urandom())));
        n_items += burst;
      end else begin
        burst = ($urandom_range(15) == 0) ? $urandom_range(120) : $urandom_range(16);
        dir = 1'($urandom());
        repeat (burst) send_word(edge_word(($urandom_range(9) == 0) ? !dir : dir));
        send_word(tick_word(pick_target()));
        n_items += burst + 1;
        n_ticks++;
      end
    end
  endtask

  // Result side: random stall, in-order compare against the owed results.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      result_cnt++;
      if (tick_results_q.size() == 0) begin
        fault_cnt++;
        $display("%0t: result word with none owed: duty %0d dir %0d speed %0d",
                 $time, rsp.duty_level, rsp.rotation_dir, $signed(rsp.speed_seen));
      end else begin
        want = tick_results_q.pop_front();
        if (rsp.duty_level !== want.duty_level) begin
          fault_cnt++;
          $display("%0t: duty_level expected %0d actual %0d",
                   $time, want.duty_level, rsp.duty_level);
        end
        if (rsp.rotation_dir !== want.rotation_dir) begin
          fault_cnt++;
          $display("%0t: rotation_dir expected %0d actual %0d",
                   $time, want.rotation_dir, rsp.rotation_dir);
        end
        if (rsp.speed_seen !== want.speed_seen) begin
          fault_cnt++;
          $display("%0t: speed_seen expected %0d actual %0d",
                   $time, $signed(want.speed_seen), $signed(rsp.speed_seen));
        end
      end
    end
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_gap_pct   = 23;
    recv_stall_pct = 53;
    test_default_registers();
    test_small_negative_drive();
    test_register_extremes();
    test_unused_indexes();
    test_long_runs();

    // receiver idles more, then sender idles more, then no idling at all
    for (int phase = 0; phase < 3; phase++) begin
      send_gap_pct   = (phase == 0) ? 23 : (phase == 1) ? 53 : 0;
      recv_stall_pct = (phase == 0) ? 53 : (phase == 1) ? 23 : 0;
      random_config();
      test_random_traffic(90, 8);
      random_config();
      test_random_traffic(90, 8);
    end

    settle();
    $display("sent %0d encoder edges and %0d ticks, %0d result words checked",
             edge_cnt, tick_cnt, result_cnt);
    $display("%0d register writes across default, extreme and random settings",
             write_cnt);
    if (fault_cnt == 0) begin
      $display("encoder_pid_speed_controller regression: pass");
    end else begin
      $display("encoder_pid_speed_controller regression: fail");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d result words still owed", tick_results_q.size());
    $display("encoder_pid_speed_controller regression: fail");
    $finish;
  end

endmodule

// ===== encoder_pid_speed_controller.f =====
+incdir+src
src/ecpsc_pkg.sv
src/encoder_pid_speed_controller.sv
tb/sv/tb_encoder_pid_speed_controller.sv
